// ----- hdl/buh_pkg.sv -----
// Shared types and operation codes for the bounded undo/redo history.
// No dependencies; buh_cmd_if, buh_ctrl and the top level import this package.
`default_nettype none

package buh_pkg;

    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNDO = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REDO = 2'd2;

    // Status that the controller hands to the result stage.
    typedef struct packed {
        logic done;
        logic last_valid;
        logic next_valid;
        logic fwd_last;
        logic fwd_next;
        logic load;
    } buh_flags_t;

endpackage

`default_nettype wire

// ----- hdl/buh_cmd_if.sv -----
// Command channel of the undo/redo history: operation code and entry.
// Depends on buh_pkg for the width of the operation code.
`default_nettype none

interface buh_cmd_if #(
    parameter int ENTRY_WIDTH = 32
);
    import buh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [ENTRY_WIDTH-1:0] entry_data;

    modport source (output valid, output func, output entry_data, input ready);
    modport sink   (input valid, input func, input entry_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/buh_res_if.sv -----
// Result channel of the undo/redo history: outcome, top entries and counts.
// No dependencies.
`default_nettype none

interface buh_res_if #(
    parameter int ENTRY_WIDTH = 32,
    parameter int COUNT_WIDTH = 7
);
    logic                   valid;
    logic                   ready;
    logic                   done_res;
    logic                   last_valid;
    logic [ENTRY_WIDTH-1:0] last_entry;
    logic                   next_valid;
    logic [ENTRY_WIDTH-1:0] next_entry;
    logic [COUNT_WIDTH-1:0] past_count;
    logic [COUNT_WIDTH-1:0] future_count;

    modport source (
        output valid, output done_res, output last_valid, output last_entry,
        output next_valid, output next_entry, output past_count, output future_count,
        input ready
    );
    modport sink (
        input valid, input done_res, input last_valid, input last_entry,
        input next_valid, input next_entry, input past_count, input future_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/buh_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
`default_nettype none

module buh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;
endmodule

`default_nettype wire

// ----- hdl/buh_ctrl.sv -----
// Pointer registers and sequencing of the undo/redo history ring.
// Depends on buh_pkg; drives the ring RAM ports and the result stage flags.
`default_nettype none

module buh_ctrl #(
    parameter int DEPTH       = 64,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [buh_pkg::FUNC_W-1:0] in_func,
    input  wire logic [ENTRY_WIDTH-1:0]     in_data,
    output logic                            in_ready,
    input  wire logic                       out_free,
    output logic                            wr_en,
    output logic [$clog2(DEPTH)-1:0]        wr_addr,
    output logic                            rd_en,
    output logic [$clog2(DEPTH)-1:0]        rd_addr_a,
    output logic [$clog2(DEPTH)-1:0]        rd_addr_b,
    output logic [ENTRY_WIDTH-1:0]          fwd_data,
    output buh_pkg::buh_flags_t             flags,
    output logic [$clog2(DEPTH+1)-1:0]      past_count,
    output logic [$clog2(DEPTH+1)-1:0]      future_count
);
    import buh_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] past_reg, past_next;
    logic [CNT_W-1:0] redo_reg, redo_next;
    logic             done_reg, done_next;
    logic             fwd_last_reg, fwd_next_reg;
    logic [ENTRY_WIDTH-1:0] wdata_reg;
    logic             accept;
    logic             load;

    // Ring position of an offset from the oldest entry; the sum stays below
    // twice the depth for every offset that is actually used.
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign accept = in_valid && in_ready;
    assign load   = (state_reg == ST_BUSY) && out_free;

    always_comb
    begin
        oldest_next = oldest_reg;
        past_next   = past_reg;
        redo_next   = redo_reg;
        done_next   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = ring_pos(oldest_reg, past_reg);
        if (accept)
        begin
            case (in_func)
                FUNC_ADD:
                begin
                    done_next = 1'b1;
                    wr_en     = 1'b1;
                    redo_next = '0;
                    if (past_reg == DEPTH_C)
                    begin
                        // Full past: the new entry replaces the oldest one.
                        wr_addr     = oldest_reg;
                        oldest_next = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;
                    end
                    else
                    begin
                        past_next = past_reg + 1'b1;
                    end
                end
                FUNC_UNDO:
                begin
                    if (past_reg != '0)
                    begin
                        past_next = past_reg - 1'b1;
                        redo_next = redo_reg + 1'b1;
                        done_next = 1'b1;
                    end
                end
                FUNC_REDO:
                begin
                    if (redo_reg != '0 && past_reg < DEPTH_C)
                    begin
                        past_next = past_reg + 1'b1;
                        redo_next = redo_reg - 1'b1;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    // The new top entries are read in the accept cycle, so a read of the
    // entry being written at the same edge takes the write data instead.
    assign rd_en     = accept;
    assign rd_addr_a = ring_pos(oldest_next, past_next - 1'b1);
    assign rd_addr_b = ring_pos(oldest_next, past_next);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            oldest_reg   <= '0;
            past_reg     <= '0;
            redo_reg     <= '0;
            done_reg     <= 1'b0;
            fwd_last_reg <= 1'b0;
            fwd_next_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                oldest_reg   <= oldest_next;
                past_reg     <= past_next;
                redo_reg     <= redo_next;
                done_reg     <= done_next;
                fwd_last_reg <= wr_en && (wr_addr == rd_addr_a);
                fwd_next_reg <= wr_en && (wr_addr == rd_addr_b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wdata_reg <= in_data;
        end
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign fwd_data         = wdata_reg;
    assign flags.done       = done_reg;
    assign flags.last_valid = (past_reg != '0);
    assign flags.next_valid = (redo_reg != '0);
    assign flags.fwd_last   = fwd_last_reg;
    assign flags.fwd_next   = fwd_next_reg;
    assign flags.load       = load;
    assign past_count       = past_reg;
    assign future_count     = redo_reg;
endmodule

`default_nettype wire

// ----- hdl/bounded_undo_redo_history.sv -----
// Top level of the bounded undo/redo history: ring RAM, controller, result register.
// Depends on buh_pkg, buh_cmd_if, buh_res_if, buh_ram and buh_ctrl.
//
//   Channel | Dir | Beat payload
//   --------+-----+-----------------------------------------------------------
//   cmd     | in  | func, entry_data
//   res     | out | done_res, last_valid, last_entry, next_valid, next_entry,
//           |     | past_count, future_count
//
// In the accept cycle a command updates the pointers, writes the ring RAM and issues
// both reads; the result register loads the registered read data once it is free.
// A command beat is taken only while no command is in flight; the result
// register holds its beat until taken, and the next command may be accepted
// meanwhile. Reset clears the pointers and counts; the RAM is not cleared.
`default_nettype none

module bounded_undo_redo_history #(
    parameter int DEPTH       = 64,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    buh_cmd_if.sink   cmd,
    buh_res_if.source res
);
    import buh_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr_a;
    logic [IDX_W-1:0]       rd_addr_b;
    logic [ENTRY_WIDTH-1:0] rd_data_a;
    logic [ENTRY_WIDTH-1:0] rd_data_b;
    logic [ENTRY_WIDTH-1:0] fwd_data;
    buh_flags_t             flags;
    logic [CNT_W-1:0]       past_count;
    logic [CNT_W-1:0]       future_count;
    logic                   out_free;
    logic [ENTRY_WIDTH-1:0] last_sel;
    logic [ENTRY_WIDTH-1:0] next_sel;

    logic                   out_valid_reg;
    logic                   done_reg;
    logic                   last_valid_reg;
    logic [ENTRY_WIDTH-1:0] last_entry_reg;
    logic                   next_valid_reg;
    logic [ENTRY_WIDTH-1:0] next_entry_reg;
    logic [CNT_W-1:0]       past_count_reg;
    logic [CNT_W-1:0]       future_count_reg;

    buh_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (cmd.entry_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    buh_ctrl #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmd.valid),
        .in_func      (cmd.func),
        .in_data      (cmd.entry_data),
        .in_ready     (cmd.ready),
        .out_free     (out_free),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .rd_en        (rd_en),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .fwd_data     (fwd_data),
        .flags        (flags),
        .past_count   (past_count),
        .future_count (future_count)
    );

    assign out_free = !out_valid_reg || res.ready;

    // An empty side reports zero; otherwise take the forwarded write data
    // when the read hit the entry written in the same cycle.
    always_comb
    begin
        last_sel = '0;
        next_sel = '0;
        if (flags.last_valid)
        begin
            last_sel = flags.fwd_last ? fwd_data : rd_data_a;
        end
        if (flags.next_valid)
        begin
            next_sel = flags.fwd_next ? fwd_data : rd_data_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (flags.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flags.load)
        begin
            done_reg         <= flags.done;
            last_valid_reg   <= flags.last_valid;
            last_entry_reg   <= last_sel;
            next_valid_reg   <= flags.next_valid;
            next_entry_reg   <= next_sel;
            past_count_reg   <= past_count;
            future_count_reg <= future_count;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.done_res     = done_reg;
    assign res.last_valid   = last_valid_reg;
    assign res.last_entry   = last_entry_reg;
    assign res.next_valid   = next_valid_reg;
    assign res.next_entry   = next_entry_reg;
    assign res.past_count   = past_count_reg;
    assign res.future_count = future_count_reg;

    // Past and redo entries together never exceed the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ({1'b0, res.past_count} + {1'b0, res.future_count}) <= (CNT_W + 1)'(DEPTH))
        else $error("past plus redo count exceeds the ring depth");

    // A command in flight keeps the command channel closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command accepted while another one is in flight");

    // The valid bits of a result agree with its counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.last_valid == (res.past_count != '0)) &&
                      (res.next_valid == (res.future_count != '0)))
        else $error("result valid bits disagree with its counts");

    // An empty side reports a zero entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last_valid) |-> (res.last_entry == '0))
        else $error("empty past reports a nonzero entry");
endmodule

`default_nettype wire
